@@ design/i2cm_pkg.sv @@
// Shared types and constants of the bit-level I2C master.
`default_nettype none
package i2cm_pkg;

	// Configuration port widths and register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 8'd1;

	// Register reset values.
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

	// Bits in one byte transfer on the bus.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Command codes carried in the mode field.
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WAIT  = 3'd5
	} cmd_t;

	// Bus sequencer steps, one-hot.
	typedef enum logic [16:0] {
		ST_IDLE = 17'd1,
		ST_S1   = 17'd2,
		ST_S2   = 17'd4,
		ST_S3   = 17'd8,
		ST_S4   = 17'd16,
		ST_P1   = 17'd32,
		ST_P2   = 17'd64,
		ST_P3   = 17'd128,
		ST_WA   = 17'd256,
		ST_WB   = 17'd512,
		ST_WC   = 17'd1024,
		ST_RL   = 17'd2048,
		ST_RH   = 17'd4096,
		ST_K1   = 17'd8192,
		ST_K2   = 17'd16384,
		ST_W1   = 17'd32768,
		ST_POLL = 17'd65536
	} step_t;

	// One input tick.
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} out_item_t;

	// Configuration register contents handed to the sequencer.
	typedef struct packed {
		logic [7:0] ack_timeout;
		logic [7:0] phase_ticks;
	} cfg_regs_t;

endpackage
`default_nettype wire

@@ design/i2cm_ifs.sv @@
// Channel interfaces of the bit-level I2C master: ticks, results and configuration.
`default_nettype none

// Input tick channel.
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, output mode, output tx_byte, output send_ack,
		output sda_in, input ready);
	modport sink (input valid, input mode, input tx_byte, input send_ack,
		input sda_in, output ready);
endinterface

// Result channel.
interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_failed;

	modport source (output valid, output scl_level, output sda_level, output busy_res,
		output done_res, output rx_byte, output ack_failed, input ready);
	modport sink (input valid, input scl_level, input sda_level, input busy_res,
		input done_res, input rx_byte, input ack_failed, output ready);
endinterface

// Configuration write channel.
interface i2cm_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ design/i2cm_engine.sv @@
// Bus phase sequencer of the I2C master: advances one tick per accepted item.
`default_nettype none
module i2cm_engine
	import i2cm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step_en,
	input  wire in_item_t  item,
	input  wire cfg_regs_t regs,
	output out_item_t      res
);

	step_t      step_q, n_step, tgt;
	cmd_t       active_q, n_active;
	logic [3:0] bit_cnt_q, n_bit_cnt;
	logic [7:0] shift_q, n_shift, sh_mid;
	logic [7:0] timer_q, n_timer;
	logic [7:0] poll_q, n_poll;
	logic       ack_q, n_ack;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic [7:0] rx_q, n_rx;
	logic       fail_q, n_fail;
	logic       go_enter, go_finish;
	logic [7:0] ticks;
	logic [8:0] timer_inc, poll_inc;

	assign ticks     = (regs.phase_ticks == 8'd0) ? 8'd1 : regs.phase_ticks;
	assign timer_inc = {1'b0, timer_q} + 9'd1;
	assign poll_inc  = {1'b0, poll_q} + 9'd1;

	// Next-state logic for one tick: choose a phase change, then apply its bus levels.
	always_comb begin
		n_step    = step_q;
		n_active  = active_q;
		n_bit_cnt = bit_cnt_q;
		sh_mid    = shift_q;
		n_timer   = timer_q;
		n_poll    = poll_q;
		n_ack     = ack_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_rx      = rx_q;
		n_fail    = fail_q;
		tgt       = ST_IDLE;
		go_enter  = 1'b0;
		go_finish = 1'b0;

		if (step_q == ST_IDLE) begin
			// A new command is taken only while idle; unused codes do nothing.
			case (item.mode) inside
				CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT: begin
					n_active  = cmd_t'(item.mode);
					n_fail    = 1'b0;
					n_bit_cnt = 4'd0;
					n_poll    = 8'd0;
					go_enter  = 1'b1;
					case (item.mode)
						CMD_START: tgt = ST_S1;
						CMD_STOP:  tgt = ST_P1;
						CMD_WRITE: begin
							sh_mid = item.tx_byte;
							tgt    = ST_WA;
						end
						CMD_READ: begin
							sh_mid = 8'd0;
							n_ack  = item.send_ack;
							tgt    = ST_RL;
						end
						default: tgt = ST_W1;
					endcase
				end
				default: ;
			endcase
		end else if (step_q == ST_POLL) begin
			// One poll per tick; a high line counts towards the timeout.
			if (!item.sda_in) begin
				n_scl     = 1'b0;
				go_finish = 1'b1;
			end else if (poll_inc > {1'b0, regs.ack_timeout}) begin
				n_fail   = 1'b1;
				n_poll   = 8'd0;
				tgt      = ST_P1;
				go_enter = 1'b1;
			end else begin
				n_poll = poll_inc[7:0];
			end
		end else if (timer_inc >= {1'b0, ticks}) begin
			// End of the current phase.
			unique case (step_q)
				ST_S1: begin tgt = ST_S2; go_enter = 1'b1; end
				ST_S2: begin tgt = ST_S3; go_enter = 1'b1; end
				ST_S3: begin tgt = ST_S4; go_enter = 1'b1; end
				ST_P1: begin tgt = ST_P2; go_enter = 1'b1; end
				ST_P2: begin tgt = ST_P3; go_enter = 1'b1; end
				ST_WA: begin tgt = ST_WB; go_enter = 1'b1; end
				ST_WB: begin tgt = ST_WC; go_enter = 1'b1; end
				ST_RL: begin tgt = ST_RH; go_enter = 1'b1; end
				ST_K1: begin tgt = ST_K2; go_enter = 1'b1; end
				ST_W1: begin tgt = ST_POLL; go_enter = 1'b1; end
				ST_WC: begin
					n_bit_cnt = bit_cnt_q + 4'd1;
					if (n_bit_cnt < BYTE_BITS) begin
						tgt      = ST_WA;
						go_enter = 1'b1;
					end else begin
						go_finish = 1'b1;
					end
				end
				ST_RH: begin
					sh_mid    = {shift_q[6:0], item.sda_in};
					n_bit_cnt = bit_cnt_q + 4'd1;
					tgt       = (n_bit_cnt < BYTE_BITS) ? ST_RL : ST_K1;
					go_enter  = 1'b1;
				end
				ST_K2: begin
					n_scl     = 1'b0;
					go_finish = 1'b1;
				end
				default: go_finish = 1'b1;
			endcase
		end else begin
			n_timer = timer_inc[7:0];
		end

		n_shift = sh_mid;

		// Entering a phase sets the bus levels it holds.
		if (go_enter) begin
			n_step  = tgt;
			n_timer = 8'd0;
			unique case (tgt) inside
				ST_S1, ST_P3: n_sda = 1'b1;
				ST_S3, ST_P1: n_sda = 1'b0;
				ST_S2, ST_P2, ST_WB, ST_RH, ST_K2: n_scl = 1'b1;
				ST_S4, ST_WC: n_scl = 1'b0;
				ST_WA: begin
					n_scl   = 1'b0;
					n_sda   = sh_mid[7];
					n_shift = {sh_mid[6:0], 1'b0};
				end
				ST_RL: begin
					n_scl = 1'b0;
					n_sda = 1'b1;
				end
				ST_K1: begin
					n_scl = 1'b0;
					n_sda = !n_ack;
				end
				ST_W1: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				default: ;
			endcase
		end

		// Finishing a command returns to idle and latches a read byte.
		if (go_finish) begin
			n_step  = ST_IDLE;
			n_timer = 8'd0;
			if (active_q == CMD_READ) begin
				n_rx = sh_mid;
			end
		end
	end

	// Result of this tick, taken by the output register.
	always_comb begin
		res.scl_level  = n_scl;
		res.sda_level  = n_sda;
		res.busy_res   = (n_step != ST_IDLE);
		res.done_res   = go_finish;
		res.rx_byte    = n_rx;
		res.ack_failed = n_fail;
	end

	// Sequencer state, updated on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_IDLE;
			active_q  <= CMD_NONE;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'd0;
			timer_q   <= 8'd0;
			poll_q    <= 8'd0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			rx_q      <= 8'd0;
			fail_q    <= 1'b0;
		end else if (step_en) begin
			step_q    <= n_step;
			active_q  <= n_active;
			bit_cnt_q <= n_bit_cnt;
			shift_q   <= n_shift;
			timer_q   <= n_timer;
			poll_q    <= n_poll;
			ack_q     <= n_ack;
			scl_q     <= n_scl;
			sda_q     <= n_sda;
			rx_q      <= n_rx;
			fail_q    <= n_fail;
		end
	end

`ifndef ASSERT_OFF
	// The failure flag is raised only by a timed-out poll.
	a_fail_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> $past(step_q) == ST_POLL)
		else $error("ack failure raised outside ack polling");

	// The phase timer never reaches the phase length.
	a_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		timer_q < ticks || step_q == ST_IDLE || step_q == ST_POLL)
		else $error("phase timer ran past the phase length");

	// A byte never counts past eight bits.
	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= BYTE_BITS)
		else $error("bit counter overran a byte");
`endif

endmodule
`default_nettype wire

@@ design/i2c_bit_level_master.sv @@
// Top level of the bit-level I2C master: handshakes, registers and result buffer.
//
// Usage: each transfer on the items channel is one bus timing tick carrying the
// sampled SDA level and, when the master is idle, a command in mode (start, stop,
// write byte, read byte with ACK/NACK, wait for ACK). Every tick gives exactly one
// transfer on the results channel with the SCL/SDA drive levels after the tick,
// busy and done flags, the last received byte and the ACK failure flag.
// The result of a tick is valid in the cycle after it is accepted. Throughput is
// one tick per cycle while the results channel takes each result, set by the
// sequencer update feeding a one-entry result register.
// When the results channel stalls, the result register holds and items.ready drops
// until the result is taken; no tick is lost or sampled twice.
// The cfg channel is always ready; index 0 is ack_timeout, index 1 phase_ticks,
// other indexes are ignored. Write it only while the master is idle.
// Reset puts the bus released (SCL and SDA high), the sequencer idle, the
// registers at ack_timeout 100 and phase_ticks 1, and the result buffer empty.
`default_nettype none
module i2c_bit_level_master
	import i2cm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cm_in_if.sink     items,
	i2cm_out_if.source  results,
	i2cm_cfg_if.sink    cfg
);

	cfg_regs_t regs_q;
	in_item_t  item;
	out_item_t res;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      in_fire;
	logic      out_fire;

	// Handshakes: a tick is taken whenever the result buffer is free or draining.
	assign items.ready = !out_valid_q || results.ready;
	assign in_fire     = items.valid && items.ready;
	assign out_fire    = out_valid_q && results.ready;
	assign cfg.ready   = 1'b1;

	assign item.mode     = items.mode;
	assign item.tx_byte  = items.tx_byte;
	assign item.send_ack = items.send_ack;
	assign item.sda_in   = items.sda_in;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ack_timeout <= ACK_TIMEOUT_RST;
			regs_q.phase_ticks <= PHASE_TICKS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ACK_TIMEOUT: regs_q.ack_timeout <= cfg.wdata;
				REG_PHASE_TICKS: regs_q.phase_ticks <= cfg.wdata;
				default: ;
			endcase
		end
	end

	i2cm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (in_fire),
		.item    (item),
		.regs    (regs_q),
		.res     (res)
	);

	// Result buffer valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result buffer payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.scl_level  = out_data_q.scl_level;
	assign results.sda_level  = out_data_q.sda_level;
	assign results.busy_res   = out_data_q.busy_res;
	assign results.done_res   = out_data_q.done_res;
	assign results.rx_byte    = out_data_q.rx_byte;
	assign results.ack_failed = out_data_q.ack_failed;

`ifndef ASSERT_OFF
	// Every accepted tick leaves a result waiting in the next cycle.
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted tick produced no result");

	// A waiting result that is not taken blocks new ticks.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |-> !items.ready)
		else $error("tick accepted over a stalled result");

	// A command that finishes leaves the master idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.done_res |-> !out_data_q.busy_res)
		else $error("done flagged while still busy");
`endif

endmodule
`default_nettype wire

@@ sim/i2c_bit_level_master_test.sv @@
// Self-checking testbench of the bit-level I2C master: a directed table, then random bus traffic.
`default_nettype none
module i2c_bit_level_master_test;
	import i2cm_pkg::*;

	// Mode codes that the master does not use and must ignore.
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	// An index beyond the register list.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 1000;

	// One row of the directed table: a register write, or a run of identical ticks.
	typedef struct packed {
		logic       is_cfg;
		logic [7:0] idx;
		logic [7:0] data;
		logic [2:0] mode;
		logic [7:0] tx;
		logic       sack;
		logic       sda;
		logic [7:0] reps;
		logic       typed;
		out_item_t  want;
	} drow_t;

	localparam out_item_t NO_WANT = '0;

	// Fields of want: scl, sda, busy, done, rx byte, ack failed.
	localparam drow_t DIRECTED [0:28] = '{
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, MODE_SPARE6, 8'hA5, 1'b1, 1'b1, 8'd1, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, MODE_SPARE7, 8'h5A, 1'b0, 1'b0, 8'd1, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, CMD_START, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, CMD_STOP, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd2, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, CMD_WRITE, 8'hFF, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd23, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, CMD_WAIT, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 8'd0, 8'd0, CMD_WRITE, 8'h00, 1'b1, 1'b0, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd24, 1'b0, NO_WANT},
		'{1'b1, REG_ACK_TIMEOUT, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_WAIT, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, NO_WANT},
		'{1'b1, REG_PHASE_TICKS, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, NO_WANT},
		'{1'b1, REG_UNUSED, 8'h55, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_READ, 8'h00, 1'b1, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd18, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_READ, 8'h00, 1'b0, 1'b0, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 8'd18, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_STOP, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd2, 1'b0, NO_WANT},
		'{1'b0, 8'd0, 8'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}}
	};

	logic clk;
	logic arst_n;

	i2cm_in_if  items ();
	i2cm_out_if results ();
	i2cm_cfg_if cfg ();

	i2c_bit_level_master DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg)
	);

	// Predicted sequencer state and register contents.
	step_t      bus_step;
	logic [2:0] bus_cmd;
	logic [3:0] bit_cnt;
	logic [7:0] shifter;
	logic [7:0] phase_cnt;
	logic [7:0] poll_cnt;
	logic       ack_sel;
	logic       scl_drv;
	logic       sda_drv;
	logic [7:0] rx_last;
	logic       ack_fail;
	logic [7:0] ack_timeout_reg;
	logic [7:0] phase_ticks_reg;

	out_item_t  expected_results[$];
	logic [2:0] cmd_script[$];
	int         ack_delay;
	int         errors;
	int         busy_ticks;
	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_req;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void reset_model();
		bus_step = ST_IDLE;
		bus_cmd = CMD_NONE;
		bit_cnt = '0;
		shifter = '0;
		phase_cnt = '0;
		poll_cnt = '0;
		ack_sel = 1'b0;
		scl_drv = 1'b1;
		sda_drv = 1'b1;
		rx_last = '0;
		ack_fail = 1'b0;
		ack_timeout_reg = ACK_TIMEOUT_RST;
		phase_ticks_reg = PHASE_TICKS_RST;
	endfunction

	function automatic void apply_register(logic [7:0] idx, logic [7:0] data);
		if (idx == REG_ACK_TIMEOUT) ack_timeout_reg = data;
		else if (idx == REG_PHASE_TICKS) phase_ticks_reg = data;
	endfunction

	// Entering a bus phase sets the line levels it holds.
	function automatic void enter_phase(step_t s);
		bus_step = s;
		phase_cnt = '0;
		case (s) inside
			ST_S1, ST_P3: sda_drv = 1'b1;
			ST_S3, ST_P1: sda_drv = 1'b0;
			ST_S2, ST_P2, ST_WB, ST_RH, ST_K2: scl_drv = 1'b1;
			ST_S4, ST_WC: scl_drv = 1'b0;
			ST_WA: begin
				scl_drv = 1'b0;
				sda_drv = shifter[7];
				shifter = {shifter[6:0], 1'b0};
			end
			ST_RL: begin
				scl_drv = 1'b0;
				sda_drv = 1'b1;
			end
			ST_K1: begin
				scl_drv = 1'b0;
				sda_drv = !ack_sel;
			end
			ST_W1: begin
				scl_drv = 1'b1;
				sda_drv = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic bit end_command();
		if (bus_cmd == CMD_READ) rx_last = shifter;
		bus_step = ST_IDLE;
		phase_cnt = '0;
		return 1'b1;
	endfunction

	// Leaves the current phase; returns 1 when the command has finished.
	function automatic bit next_phase(logic sda);
		case (bus_step)
			ST_S1: enter_phase(ST_S2);
			ST_S2: enter_phase(ST_S3);
			ST_S3: enter_phase(ST_S4);
			ST_P1: enter_phase(ST_P2);
			ST_P2: enter_phase(ST_P3);
			ST_WA: enter_phase(ST_WB);
			ST_WB: enter_phase(ST_WC);
			ST_RL: enter_phase(ST_RH);
			ST_K1: enter_phase(ST_K2);
			ST_W1: enter_phase(ST_POLL);
			ST_WC: begin
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt < BYTE_BITS) enter_phase(ST_WA);
				else return end_command();
			end
			ST_RH: begin
				shifter = {shifter[6:0], sda};
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt < BYTE_BITS) enter_phase(ST_RL);
				else enter_phase(ST_K1);
			end
			ST_K2: begin
				scl_drv = 1'b0;
				return end_command();
			end
			default: return end_command();
		endcase
		return 1'b0;
	endfunction

	// Works out the result of one tick and moves the predicted state on.
	function automatic out_item_t predict_tick(in_item_t t);
		out_item_t o;
		int ticks;
		int polls;
		bit done;
		ticks = (phase_ticks_reg == 8'd0) ? 1 : int'(phase_ticks_reg);
		done = 1'b0;
		if (bus_step == ST_IDLE) begin
			if (t.mode >= CMD_START && t.mode <= CMD_WAIT) begin
				busy_ticks++;
				bus_cmd = t.mode;
				ack_fail = 1'b0;
				bit_cnt = '0;
				poll_cnt = '0;
				case (t.mode)
					CMD_START: enter_phase(ST_S1);
					CMD_STOP: enter_phase(ST_P1);
					CMD_WRITE: begin
						shifter = t.tx_byte;
						enter_phase(ST_WA);
					end
					CMD_READ: begin
						shifter = '0;
						ack_sel = t.send_ack;
						enter_phase(ST_RL);
					end
					default: enter_phase(ST_W1);
				endcase
			end
		end else if (bus_step == ST_POLL) begin
			busy_ticks++;
			if (!t.sda_in) begin
				scl_drv = 1'b0;
				done = end_command();
			end else begin
				polls = int'(poll_cnt) + 1;
				// Too many high polls: flag the failure and release the bus with a stop.
				if (polls > int'(ack_timeout_reg)) begin
					ack_fail = 1'b1;
					poll_cnt = '0;
					enter_phase(ST_P1);
				end else begin
					poll_cnt = polls[7:0];
				end
			end
		end else begin
			busy_ticks++;
			phase_cnt = phase_cnt + 8'd1;
			if (int'(phase_cnt) >= ticks) done = next_phase(t.sda_in);
		end
		o.scl_level = scl_drv;
		o.sda_level = sda_drv;
		o.busy_res = (bus_step != ST_IDLE);
		o.done_res = done;
		o.rx_byte = rx_last;
		o.ack_failed = ack_fail;
		return o;
	endfunction

	// Mostly whole bus transactions, now and then a stray command.
	function automatic void plan_transaction();
		int n;
		if ($urandom_range(99) < 15) begin
			cmd_script.push_back(3'($urandom_range(7)));
		end else begin
			cmd_script.push_back(CMD_START);
			cmd_script.push_back(CMD_WRITE);
			cmd_script.push_back(CMD_WAIT);
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(1)) begin
					cmd_script.push_back(CMD_WRITE);
					cmd_script.push_back(CMD_WAIT);
				end else begin
					cmd_script.push_back(CMD_READ);
				end
			end
			// Leaving the stop out gives a repeated start next time.
			if ($urandom_range(99) < 80) cmd_script.push_back(CMD_STOP);
		end
	endfunction

	// Number of high polls before the slave pulls SDA low.
	function automatic int plan_ack_delay();
		int r;
		r = $urandom_range(99);
		if (r < 55) return $urandom_range(3);
		if (r < 70) return int'(ack_timeout_reg);
		if (r < 80) return int'(ack_timeout_reg) + 1;
		return $urandom_range(int'(ack_timeout_reg) + 3);
	endfunction

	function automatic in_item_t next_tick();
		in_item_t t;
		t.mode = CMD_NONE;
		t.tx_byte = 8'($urandom_range(255));
		t.send_ack = 1'($urandom_range(1));
		t.sda_in = 1'($urandom_range(1));
		if (bus_step == ST_IDLE) begin
			if (cmd_script.size() == 0) plan_transaction();
			if ($urandom_range(99) >= 20) t.mode = cmd_script.pop_front();
			if (t.mode == CMD_WAIT) ack_delay = plan_ack_delay();
		end else begin
			// Commands offered while busy must be ignored.
			if ($urandom_range(99) < 30) t.mode = 3'($urandom_range(7));
			if (bus_step == ST_POLL) begin
				t.sda_in = (ack_delay != 0);
				if (ack_delay > 0) ack_delay--;
			end
		end
		return t;
	endfunction

	// Offers one tick, starting at a falling edge, and records its expected result.
	task automatic send_tick(in_item_t t, bit typed, out_item_t want);
		out_item_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid <= 1'b1;
		items.mode <= t.mode;
		items.tx_byte <= t.tx_byte;
		items.send_ack <= t.send_ack;
		items.sda_in <= t.sda_in;
		do @(posedge clk); while (!items.ready);
		guess = predict_tick(t);
		expected_results.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	// Leaves the configuration valid high; the caller lowers it after its last write.
	task automatic write_register(logic [7:0] idx, logic [7:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= data;
		do @(posedge clk); while (!cfg.ready);
		apply_register(idx, data);
		@(negedge clk);
	endtask

	// Stops offering ticks and waits until every result has been taken.
	task automatic settle();
		items.valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic run_segment(int timeout_val, int ticks_val, int sidle, int ridle,
			int budget, bit with_hold);
		int first;
		settle();
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		write_register(REG_ACK_TIMEOUT, 8'(timeout_val));
		write_register(REG_PHASE_TICKS, 8'(ticks_val));
		write_register(8'($urandom_range(2, 255)), 8'($urandom_range(255)));
		cfg.valid <= 1'b0;
		cmd_script.delete();
		if (with_hold) hold_req = 1'b1;
		first = busy_ticks;
		while (busy_ticks - first < budget) send_tick(next_tick(), 1'b0, NO_WANT);
		// Let the command in flight run to its end before the next register write.
		while (bus_step != ST_IDLE) send_tick(next_tick(), 1'b0, NO_WANT);
	endtask

	task automatic compare_result(out_item_t got, out_item_t want);
		if (got.scl_level !== want.scl_level) begin
			$error("scl_level: expected %0b, actual %0b", want.scl_level, got.scl_level);
			errors++;
		end
		if (got.sda_level !== want.sda_level) begin
			$error("sda_level: expected %0b, actual %0b", want.sda_level, got.sda_level);
			errors++;
		end
		if (got.busy_res !== want.busy_res) begin
			$error("busy_res: expected %0b, actual %0b", want.busy_res, got.busy_res);
			errors++;
		end
		if (got.done_res !== want.done_res) begin
			$error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
			errors++;
		end
		if (got.rx_byte !== want.rx_byte) begin
			$error("rx_byte: expected 0x%02h, actual 0x%02h", want.rx_byte, got.rx_byte);
			errors++;
		end
		if (got.ack_failed !== want.ack_failed) begin
			$error("ack_failed: expected %0b, actual %0b", want.ack_failed, got.ack_failed);
			errors++;
		end
	endtask

	// Result side: random back-pressure, one long hold-off on request, and the checks.
	initial begin
		out_item_t got;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			results.ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (results.valid && results.ready) begin
				got.scl_level = results.scl_level;
				got.sda_level = results.sda_level;
				got.busy_res = results.busy_res;
				got.done_res = results.done_res;
				got.rx_byte = results.rx_byte;
				got.ack_failed = results.ack_failed;
				if (expected_results.size() == 0) begin
					$error("result transfer with no tick pending");
					errors++;
				end else begin
					compare_result(got, expected_results.pop_front());
				end
			end
		end
	end

	// Tick and configuration side.
	initial begin
		in_item_t t;
		int waited;
		arst_n = 1'b0;
		items.valid <= 1'b0;
		items.mode <= CMD_NONE;
		items.tx_byte <= '0;
		items.send_ack <= 1'b0;
		items.sda_in <= 1'b1;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.wdata <= '0;
		errors = 0;
		busy_ticks = 0;
		hold_req = 1'b0;
		ack_delay = 0;
		send_idle_pct = 15;
		recv_idle_pct = 81;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg) begin
				settle();
				write_register(DIRECTED[i].idx, DIRECTED[i].data);
				cfg.valid <= 1'b0;
			end else begin
				t.mode = DIRECTED[i].mode;
				t.tx_byte = DIRECTED[i].tx;
				t.send_ack = DIRECTED[i].sack;
				t.sda_in = DIRECTED[i].sda;
				repeat (DIRECTED[i].reps) send_tick(t, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		// Random traffic under several settings.
		run_segment(3, 1, 15, 81, 300, 1'b0);
		run_segment(1, 2, 15, 81, 150, 1'b0);
		run_segment(255, 1, 81, 15, 250, 1'b0);
		run_segment($urandom_range(1, 10), 3, 81, 15, 150, 1'b0);
		run_segment(2, 12, 0, 0, 300, 1'b0);
		run_segment($urandom_range(1, 20), 1, 0, 0, 250, 1'b1);

		// Wait for the last results.
		items.valid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		repeat (4) @(negedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung run.
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
